>>> src/fpa_pkg.sv
// fixed_point_alu package: opcodes, widths and shared types
// used by every module of the fixed-point ALU
package fpa_pkg;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 4;
    localparam int FRAC_BITS_D = 8;

    localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
    localparam logic [OP_W-1:0] OP_CMP  = 4'd4;
    localparam logic [OP_W-1:0] OP_MIN  = 4'd5;
    localparam logic [OP_W-1:0] OP_MAX  = 4'd6;
    localparam logic [OP_W-1:0] OP_INC  = 4'd7;
    localparam logic [OP_W-1:0] OP_DEC  = 4'd8;
    localparam logic [OP_W-1:0] OP_FINT = 4'd9;
    localparam logic [OP_W-1:0] OP_TINT = 4'd10;

    // per-beat side info carried down the pipeline
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] simple;   // result of the combinational ops
        logic              lt;
        logic              eq;
        logic              gt;
        logic              dz;
    } t_side;
endpackage

>>> src/fpa_mul.sv
// fixed_point_alu pipelined multiplier: four 16x16 partial products
// then sum and shift; depends on fpa_pkg
module fpa_mul import fpa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_D
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic        [DATA_W-1:0] o_p
);
    // a*b split as (ah*2^16+al)*(bh*2^16+bl), ah/bh signed
    logic signed [33:0] r_hh, r_hl, r_lh;
    logic        [31:0] r_ll;
    logic signed [63:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= 34'($signed(i_a[31:16]) * $signed(i_b[31:16]));
            r_hl <= 34'($signed(i_a[31:16]) * $signed({1'b0, i_b[15:0]}));
            r_lh <= 34'($signed(i_b[31:16]) * $signed({1'b0, i_a[15:0]}));
            r_ll <= 32'(i_a[15:0] * i_b[15:0]);
            r_sum <= (64'(r_hh) <<< 32) + (64'(r_hl) <<< 16) + (64'(r_lh) <<< 16)
                     + $signed({32'd0, r_ll});
        end
    end
    assign o_p = r_sum[FRAC_BITS +: DATA_W];
endmodule

>>> src/fpa_div.sv
// fixed_point_alu divider: restoring division of the magnitudes, four
// quotient bits per pipeline stage; depends on fpa_pkg
module fpa_div import fpa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_D
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic        [DATA_W-1:0] o_q
);
    localparam int NW  = DATA_W + FRAC_BITS;   // numerator magnitude bits
    localparam int BPS = 4;                     // quotient bits per stage
    localparam int NST = (NW + BPS - 1) / BPS;
    localparam int TW  = NST * BPS;

    logic [TW-1:0]     r_num [NST+1];
    logic [DATA_W:0]   r_rem [NST+1];
    logic [DATA_W-1:0] r_den [NST+1];
    logic              r_neg [NST+1];

    logic [NW-1:0] n_mag;
    always_comb begin
        n_mag = i_a[DATA_W-1] ? NW'(-{{FRAC_BITS{i_a[DATA_W-1]}}, i_a}) : NW'(i_a);
        n_mag = NW'(n_mag << FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= TW'(n_mag);
            r_rem[0] <= '0;
            r_den[0] <= i_b[DATA_W-1] ? DATA_W'(-i_b) : DATA_W'(i_b);
            r_neg[0] <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
        end
    end

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [TW-1:0]   n_num;
        logic [DATA_W:0] n_rem;
        always_comb begin
            n_num = r_num[s];
            n_rem = r_rem[s];
            for (int k = 0; k < BPS; k++) begin
                n_rem = {n_rem[DATA_W-1:0], n_num[TW-1]};
                n_num = {n_num[TW-2:0], 1'b0};
                if (n_rem >= {1'b0, r_den[s]}) begin
                    n_rem = n_rem - {1'b0, r_den[s]};
                    n_num[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1] <= n_num;
                r_rem[s+1] <= n_rem;
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    logic [DATA_W-1:0] w_q;
    assign w_q = r_num[NST][DATA_W-1:0];
    assign o_q = r_neg[NST] ? DATA_W'(-w_q) : w_q;
endmodule

>>> src/fixed_point_alu_top.sv
// fixed_point_alu top level: handshake, combinational ops, pipeline alignment
// depends on fpa_pkg, fpa_mul, fpa_div
//
// channel | dir | tdata fields (low bit up)                    | tuser
// s_axis  | in  | operand_a[31:0] operand_b[63:32]             | opcode[3:0]
// m_axis  | out | result_value[31:0] less equal greater dzero  | none
//
// every op takes the same latency from the accepting edge to the first edge the
// result beat can be taken, set by the divider's stage count; one beat may enter
// each cycle while the output is free or taken
// the whole pipeline advances together only while the output is free or taken,
// so a stall freezes every stage and nothing is dropped or repeated
// reset (i_rst_n low, synchronous) clears all valid bits; data needs none
module fixed_point_alu_top import fpa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
    input  logic [3:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // result_value, a_less, a_equal, a_greater,
                                        // divide_error, zero pad
);
    localparam int NW  = DATA_W + FRAC_BITS;
    localparam int NST = (NW + 3) / 4;
    localparam int DL  = NST + 1;   // divider latency from i_en at input
    localparam int ML  = 2;         // multiplier latency

    logic adv;
    logic r_v [DL+1];
    assign adv = !r_v[DL] || m_axis_tready;
    assign s_axis_tready = adv;

    logic signed [DATA_W-1:0] w_a, w_b;
    logic [OP_W-1:0] w_op;
    assign w_a  = s_axis_tdata[31:0];
    assign w_b  = s_axis_tdata[63:32];
    assign w_op = s_axis_tuser;

    // combinational ops and flags
    t_side n_side;
    always_comb begin
        n_side.op = w_op;
        n_side.lt = w_a < w_b;
        n_side.eq = w_a == w_b;
        n_side.gt = w_a > w_b;
        n_side.dz = (w_op == OP_DIV) && (w_b == '0);
        case (w_op)
            OP_ADD:  n_side.simple = w_a + w_b;
            OP_SUB:  n_side.simple = w_a - w_b;
            OP_MIN:  n_side.simple = n_side.lt ? w_a : w_b;
            OP_MAX:  n_side.simple = n_side.gt ? w_a : w_b;
            OP_INC:  n_side.simple = w_a + 1;
            OP_DEC:  n_side.simple = w_a - 1;
            OP_FINT: n_side.simple = w_a << FRAC_BITS;
            OP_TINT: n_side.simple = w_a >>> FRAC_BITS;
            default: n_side.simple = '0;
        endcase
    end

    // side info delay line, aligned to the divider output
    t_side r_side [DL];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DL; i++) r_v[i] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= s_axis_tvalid;
            for (int i = 1; i <= DL; i++) r_v[i] <= r_v[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            for (int i = 1; i < DL; i++) r_side[i] <= r_side[i-1];
        end
    end

    // multiplier product delayed to the same point
    logic [DATA_W-1:0] w_p, w_q;
    logic [DATA_W-1:0] r_pd [DL-ML];
    fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_en(adv), .i_a(w_a), .i_b(w_b), .o_p(w_p)
    );
    fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_en(adv), .i_a(w_a), .i_b(w_b), .o_q(w_q)
    );
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pd[0] <= w_p;
            for (int i = 1; i < DL-ML; i++) r_pd[i] <= r_pd[i-1];
        end
    end

    // r_side[DL-1] lines up with the divider output; r_pd[k] lines up with r_side[k+ML]
    t_side s;
    logic [DATA_W-1:0] w_res;
    assign s = r_side[DL-1];
    always_comb begin
        case (s.op)
            OP_MUL:  w_res = r_pd[DL-ML-1];
            OP_DIV:  w_res = s.dz ? '0 : w_q;
            default: w_res = s.simple;
        endcase
    end

    // output register
    logic [39:0] r_out;
    always_ff @(posedge i_clk) begin
        if (adv) r_out <= {4'b0000, s.dz, s.gt, s.eq, s.lt, w_res};
    end
    assign m_axis_tvalid = r_v[DL];
    assign m_axis_tdata  = r_out;

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata);
    endproperty
    a_hold: assert property (p_hold) else $error("output changed under stall");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot(m_axis_tdata[34:32]))
        else $error("compare flags not one-hot");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[35] |-> m_axis_tdata[31:0] == '0)
        else $error("divide by zero with nonzero result");
endmodule
